### rtl/wvoe_pkg.sv
// shared types and constants for the wavetable voice oscillator and envelope unit
`timescale 1ns / 1ps

package wvoe_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_KEY_ON  = 2'd1;
   localparam logic [1:0] OP_KEY_OFF = 2'd2;
   localparam logic [1:0] OP_CLR_IRQ = 2'd3;

   localparam logic [2:0] REG_OSC_FREQ       = 3'd0;
   localparam logic [2:0] REG_OSC_LOOP_START = 3'd1;
   localparam logic [2:0] REG_OSC_LOOP_END   = 3'd2;
   localparam logic [2:0] REG_OSC_MODE       = 3'd3;
   localparam logic [2:0] REG_VOL_LOOP_START = 3'd4;
   localparam logic [2:0] REG_VOL_LOOP_END   = 3'd5;
   localparam logic [2:0] REG_VOL_RATE       = 3'd6;
   localparam logic [2:0] REG_VOL_MODE       = 3'd7;

   localparam int QUEUE_DEPTH = 2;

   // decoded command passed from the front end to the back end
   typedef struct packed {
      logic        tick;
      logic        key_on;
      logic        key_off;
      logic        clr_irq;
      logic [31:0] start_position;
      logic [25:0] start_level;
   } cmd_type;

endpackage

### rtl/wvoe_front.sv
// front end: accepts request transactions and decodes the operation
`timescale 1ns / 1ps

module wvoe_front
   import wvoe_pkg::*;
(
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_start_position,
   input  logic [15:0] req_start_level,
   input  logic        queue_full,
   output logic        push,
   output cmd_type     push_cmd
);

   always_comb begin
      push_cmd = '0;
      unique case (req_op)
         OP_TICK:    push_cmd.tick    = 1'b1;
         OP_KEY_ON:  push_cmd.key_on  = 1'b1;
         OP_KEY_OFF: push_cmd.key_off = 1'b1;
         default:    push_cmd.clr_irq = 1'b1;
      endcase
      push_cmd.start_position = req_start_position;
      push_cmd.start_level    = {req_start_level, 10'd0};
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

endmodule

### rtl/wvoe_queue.sv
// two-entry command queue between front end and back end
`timescale 1ns / 1ps

module wvoe_queue
   import wvoe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            q_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign pop_cmd   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/wvoe_back.sv
// back end: control registers, voice state, per-tick step and response register
`timescale 1ns / 1ps

module wvoe_back
   import wvoe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [19:0] rsp_sample_address,
   output logic [8:0]  rsp_fraction,
   output logic [11:0] rsp_volume_index,
   output logic        rsp_is_playing,
   output logic        rsp_osc_irq_flag,
   output logic        rsp_vol_irq_flag,
   output logic        rsp_irq_event
);

   // control registers
   logic [15:0] osc_freq_ff;
   logic [31:0] osc_loop_start_ff;
   logic [31:0] osc_loop_end_ff;
   logic [4:0]  osc_mode_ff;
   logic [7:0]  vol_loop_start_ff;
   logic [7:0]  vol_loop_end_ff;
   logic [7:0]  vol_rate_ff;
   logic [3:0]  vol_mode_ff;

   // voice state
   logic [31:0] phase_acc_ff, phase_acc_in;
   logic        phase_reverse_ff, phase_reverse_in;
   logic        phase_stopped_ff, phase_stopped_in;
   logic [31:0] env_level_ff, env_level_in;
   logic        env_reverse_ff, env_reverse_in;
   logic        env_done_ff, env_done_in;
   logic        env_stopped_ff, env_stopped_in;
   logic        voice_on_ff, voice_on_in;
   logic        osc_pending_ff, osc_pending_in;
   logic        env_pending_ff, env_pending_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_addr_ff;
   logic [8:0]  rsp_frac_ff;
   logic [11:0] rsp_vidx_ff;
   logic        rsp_play_ff, rsp_play_in;
   logic        rsp_oirq_ff, rsp_virq_ff;
   logic        rsp_event_ff, rsp_event_in;

   logic        take;
   logic        playing;
   logic [31:0] osc_step, osc_pos, osc_dist;
   logic        osc_hit, osc_rev_flip;
   logic [31:0] env_lo, env_hi, env_add, env_pos, env_dist;
   logic        env_hit, env_rev_flip;

   assign take    = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign cmd_pop = take;
   assign playing = voice_on_ff && !((env_done_ff || env_stopped_ff) && phase_stopped_ff);

   // oscillator step datapath
   always_comb begin
      osc_step = {14'd0, osc_freq_ff, 2'b00};
      if (phase_reverse_ff) begin
         osc_pos  = phase_acc_ff - osc_step;
         osc_dist = osc_pos - osc_loop_start_ff;
      end else begin
         osc_pos  = phase_acc_ff + osc_step;
         osc_dist = osc_loop_end_ff - osc_pos;
      end
      osc_hit      = !((osc_dist != '0) && !osc_dist[31]);
      osc_rev_flip = phase_reverse_ff ^ osc_mode_ff[1];
   end

   // envelope step datapath
   always_comb begin
      env_lo = {6'd0, vol_loop_start_ff, 18'd0};
      env_hi = {6'd0, vol_loop_end_ff, 18'd0};
      case (vol_rate_ff[7:6])
         2'd0:    env_add = {16'd0, vol_rate_ff[5:0], 10'd0};
         2'd1:    env_add = {19'd0, vol_rate_ff[5:0], 7'd0};
         2'd2:    env_add = {22'd0, vol_rate_ff[5:0], 4'd0};
         default: env_add = {25'd0, vol_rate_ff[5:0], 1'd0};
      endcase
      if (env_reverse_ff) begin
         env_pos  = env_level_ff - env_add;
         env_dist = env_pos - env_lo;
      end else begin
         env_pos  = env_level_ff + env_add;
         env_dist = env_hi - env_pos;
      end
      env_hit      = !((env_dist != '0) && !env_dist[31]);
      env_rev_flip = env_reverse_ff ^ vol_mode_ff[1];
   end

   always_comb begin
      phase_acc_in     = phase_acc_ff;
      phase_reverse_in = phase_reverse_ff;
      phase_stopped_in = phase_stopped_ff;
      env_level_in     = env_level_ff;
      env_reverse_in   = env_reverse_ff;
      env_done_in      = env_done_ff;
      env_stopped_in   = env_stopped_ff;
      voice_on_in      = voice_on_ff;
      osc_pending_in   = osc_pending_ff;
      env_pending_in   = env_pending_ff;
      rsp_event_in     = 1'b0;

      if (cmd.tick) begin
         if (playing) begin
            if (!phase_stopped_ff) begin
               phase_acc_in = osc_pos;
               if (osc_hit) begin
                  if (osc_mode_ff[2]) begin
                     osc_pending_in = 1'b1;
                     rsp_event_in   = 1'b1;
                  end
                  if (osc_mode_ff[0]) begin
                     if (osc_mode_ff[1]) begin
                        phase_reverse_in = osc_rev_flip;
                     end
                     phase_acc_in = (osc_mode_ff[1] ? osc_rev_flip : phase_reverse_ff) ?
                                    osc_loop_end_ff + osc_dist :
                                    osc_loop_start_ff - osc_dist;
                  end else begin
                     voice_on_in      = 1'b0;
                     phase_stopped_in = 1'b1;
                     phase_acc_in     = phase_reverse_ff ? osc_loop_end_ff : osc_loop_start_ff;
                  end
               end
            end
            // the envelope still steps when the oscillator just turned the voice off
            if (!(env_done_ff || env_stopped_ff)) begin
               env_level_in = env_pos;
               if (env_hit) begin
                  if (vol_mode_ff[2]) begin
                     env_pending_in = 1'b1;
                     rsp_event_in   = 1'b1;
                  end
                  if (!osc_mode_ff[4]) begin
                     if (vol_mode_ff[0]) begin
                        if (vol_mode_ff[1]) begin
                           env_reverse_in = env_rev_flip;
                        end
                        env_level_in = (vol_mode_ff[1] ? env_rev_flip : env_reverse_ff) ?
                                       env_hi + env_dist : env_lo - env_dist;
                     end else begin
                        voice_on_in  = 1'b0;
                        env_done_in  = 1'b1;
                        env_level_in = env_reverse_ff ? env_hi : env_lo;
                     end
                  end
               end
            end
         end
      end else if (cmd.key_on) begin
         voice_on_in      = 1'b1;
         phase_acc_in     = cmd.start_position;
         env_level_in     = {6'd0, cmd.start_level};
         phase_stopped_in = 1'b0;
         env_stopped_in   = 1'b0;
         env_done_in      = 1'b0;
         phase_reverse_in = osc_mode_ff[3];
         env_reverse_in   = vol_mode_ff[3];
      end else if (cmd.key_off) begin
         phase_stopped_in = 1'b1;
         env_stopped_in   = 1'b1;
         voice_on_in      = 1'b0;
      end else begin
         osc_pending_in = 1'b0;
         env_pending_in = 1'b0;
      end

      rsp_play_in = voice_on_in && !((env_done_in || env_stopped_in) && phase_stopped_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         osc_freq_ff       <= '0;
         osc_loop_start_ff <= '0;
         osc_loop_end_ff   <= '0;
         osc_mode_ff       <= '0;
         vol_loop_start_ff <= '0;
         vol_loop_end_ff   <= '0;
         vol_rate_ff       <= '0;
         vol_mode_ff       <= 4'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_OSC_FREQ:       osc_freq_ff       <= csr_wdata[15:0];
            REG_OSC_LOOP_START: osc_loop_start_ff <= csr_wdata;
            REG_OSC_LOOP_END:   osc_loop_end_ff   <= csr_wdata;
            REG_OSC_MODE:       osc_mode_ff       <= csr_wdata[4:0];
            REG_VOL_LOOP_START: vol_loop_start_ff <= csr_wdata[7:0];
            REG_VOL_LOOP_END:   vol_loop_end_ff   <= csr_wdata[7:0];
            REG_VOL_RATE:       vol_rate_ff       <= csr_wdata[7:0];
            default:            vol_mode_ff       <= csr_wdata[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff     <= '0;
         phase_reverse_ff <= 1'b0;
         phase_stopped_ff <= 1'b1;
         env_level_ff     <= '0;
         env_reverse_ff   <= 1'b0;
         env_done_ff      <= 1'b0;
         env_stopped_ff   <= 1'b1;
         voice_on_ff      <= 1'b0;
         osc_pending_ff   <= 1'b0;
         env_pending_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_acc_ff     <= phase_acc_in;
            phase_reverse_ff <= phase_reverse_in;
            phase_stopped_ff <= phase_stopped_in;
            env_level_ff     <= env_level_in;
            env_reverse_ff   <= env_reverse_in;
            env_done_ff      <= env_done_in;
            env_stopped_ff   <= env_stopped_in;
            voice_on_ff      <= voice_on_in;
            osc_pending_ff   <= osc_pending_in;
            env_pending_ff   <= env_pending_in;
         end
      end
   end

   // address, fraction and volume index come from the state before the step; the playing and irq flags from after it
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_addr_ff  <= phase_acc_ff[31:12];
         rsp_frac_ff  <= phase_acc_ff[11:3];
         rsp_vidx_ff  <= env_level_ff[25:14];
         rsp_play_ff  <= rsp_play_in;
         rsp_oirq_ff  <= osc_pending_in;
         rsp_virq_ff  <= env_pending_in;
         rsp_event_ff <= rsp_event_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_address = rsp_addr_ff;
   assign rsp_fraction       = rsp_frac_ff;
   assign rsp_volume_index   = rsp_vidx_ff;
   assign rsp_is_playing     = rsp_play_ff;
   assign rsp_osc_irq_flag   = rsp_oirq_ff;
   assign rsp_vol_irq_flag   = rsp_virq_ff;
   assign rsp_irq_event      = rsp_event_ff;

endmodule

### rtl/wavetable_voice_oscillator_envelope_unit.sv
// top level of the wavetable voice oscillator and envelope unit
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  op, start_position, start_level
//   rsp      out        rsp_valid/rsp_stall  address, fraction, volume index, flags
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// one transaction per cycle sustained while the response is not stalled; the voice step is a
// combinational add, bound compare and reload in the back end.
// an accepted request is written into the queue, then stepped into the response register, which raises response valid.
// the two-entry queue accepts requests while the response register is stalled, until it is full.
// reset is synchronous and sets all control and voice state to its reset values; no clearing pass.
`timescale 1ns / 1ps

module wavetable_voice_oscillator_envelope_unit
   import wvoe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_start_position,
   input  logic [15:0] req_start_level,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [19:0] rsp_sample_address,
   output logic [8:0]  rsp_fraction,
   output logic [11:0] rsp_volume_index,
   output logic        rsp_is_playing,
   output logic        rsp_osc_irq_flag,
   output logic        rsp_vol_irq_flag,
   output logic        rsp_irq_event,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic    push, pop, full, not_empty;
   cmd_type push_cmd, pop_cmd;

   wvoe_front u_front (
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_start_position (req_start_position),
      .req_start_level    (req_start_level),
      .queue_full         (full),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   wvoe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .not_empty (not_empty),
      .pop       (pop),
      .pop_cmd   (pop_cmd)
   );

   wvoe_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd_valid          (not_empty),
      .cmd                (pop_cmd),
      .cmd_pop            (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_address (rsp_sample_address),
      .rsp_fraction       (rsp_fraction),
      .rsp_volume_index   (rsp_volume_index),
      .rsp_is_playing     (rsp_is_playing),
      .rsp_osc_irq_flag   (rsp_osc_irq_flag),
      .rsp_vol_irq_flag   (rsp_vol_irq_flag),
      .rsp_irq_event      (rsp_irq_event)
   );

endmodule

### rtl/wvoe_checker.sv
// port-level assertions for the voice unit, bound to the top level
`timescale 1ns / 1ps

module wvoe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_op,
   input logic [31:0] req_start_position,
   input logic [15:0] req_start_level,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [19:0] rsp_sample_address,
   input logic [8:0]  rsp_fraction,
   input logic [11:0] rsp_volume_index,
   input logic        rsp_is_playing,
   input logic        rsp_osc_irq_flag,
   input logic        rsp_vol_irq_flag,
   input logic        rsp_irq_event,
   input logic        csr_wr_en,
   input logic [2:0]  csr_index,
   input logic [31:0] csr_wdata
);

   // no response and no request stall right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("response or stall present after reset");

   // an irq event always leaves a pending flag
   a_event_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_event |-> rsp_osc_irq_flag || rsp_vol_irq_flag)
      else $error("irq event without pending flag");

   // a stalled response stays valid and holds its address, volume index and irq event
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_address)
         && $stable(rsp_volume_index) && $stable(rsp_irq_event))
      else $error("stalled response changed");

   // a request stall only follows accepted traffic
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("request stall without accepted request");

endmodule

bind wavetable_voice_oscillator_envelope_unit wvoe_checker u_wvoe_checker (.*);
